// ===== hw/rtl/tbc_pkg.sv =====
// Shared constants and types for the triangle barycentric coordinates block.
package tbc_pkg;

	// Default coordinate width and weight fraction bits
	localparam int COORD_WIDTH      = 32;
	localparam int WEIGHT_FRAC_BITS = 24;

	// Weight word width, and quotient bits kept by the divider (one guard bit)
	localparam int WEIGHT_WIDTH = 32;
	localparam int QUOT_BITS    = WEIGHT_WIDTH + 1;

	// Side-band control that travels down the divider pipeline
	typedef struct packed {
		logic valid;
		logic degen;
	} tag_t;

endpackage

// ===== hw/rtl/tbc_if.sv =====
// Stream interfaces for the query and weight channels.
interface tbc_query_if #(
	parameter int CW = tbc_pkg::COORD_WIDTH
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] c_x;
	logic signed [CW-1:0] c_y;
	logic signed [CW-1:0] p_x;
	logic signed [CW-1:0] p_y;

	modport source(output valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, input ready);
	modport sink(input valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, output ready);
endinterface

interface tbc_weight_if;
	logic valid;
	logic ready;
	logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] alpha;
	logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] beta;
	logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] gamma;
	logic degenerate;
	logic saturated;

	modport source(output valid, alpha, beta, gamma, degenerate, saturated, input ready);
	modport sink(input valid, alpha, beta, gamma, degenerate, saturated, output ready);
endinterface

// ===== hw/rtl/tbc_front.sv =====
// Edge differences, products and determinant/numerators (three stages).
module tbc_front #(
	parameter int CW = tbc_pkg::COORD_WIDTH,
	localparam int DW = CW + 1,
	localparam int PW = 2 * DW,
	localparam int NW = PW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic signed [CW-1:0] c_x,
	input  logic signed [CW-1:0] c_y,
	input  logic signed [CW-1:0] p_x,
	input  logic signed [CW-1:0] p_y,
	output logic                 v_out,
	output logic signed [NW-1:0] det,
	output logic signed [NW-1:0] num_a,
	output logic signed [NW-1:0] num_b
);

	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] t00_s1, t01_s1, t10_s1, t11_s1, vx_s1, vy_s1;
	logic signed [PW-1:0] d0_s2, d1_s2, a0_s2, a1_s2, b0_s2, b1_s2;
	logic signed [NW-1:0] det_s3, na_s3, nb_s3;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Differences relative to corner C
	always_ff @(posedge clk) begin
		if (en) begin
			t00_s1 <= DW'(a_x) - DW'(c_x);
			t01_s1 <= DW'(b_x) - DW'(c_x);
			t10_s1 <= DW'(a_y) - DW'(c_y);
			t11_s1 <= DW'(b_y) - DW'(c_y);
			vx_s1  <= DW'(p_x) - DW'(c_x);
			vy_s1  <= DW'(p_y) - DW'(c_y);
		end
	end

	// Six independent products
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s2 <= t00_s1 * t11_s1;
			d1_s2 <= t01_s1 * t10_s1;
			a0_s2 <= t11_s1 * vx_s1;
			a1_s2 <= t01_s1 * vy_s1;
			b0_s2 <= t00_s1 * vy_s1;
			b1_s2 <= t10_s1 * vx_s1;
		end
	end

	// Determinant and adjugate numerators
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= NW'(d0_s2) - NW'(d1_s2);
			na_s3  <= NW'(a0_s2) - NW'(a1_s2);
			nb_s3  <= NW'(b0_s2) - NW'(b1_s2);
		end
	end

	assign v_out = v_s3;
	assign det   = det_s3;
	assign num_a = na_s3;
	assign num_b = nb_s3;

endmodule

// ===== hw/rtl/tbc_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
module tbc_div #(
	parameter int CW = tbc_pkg::COORD_WIDTH,
	parameter int WF = tbc_pkg::WEIGHT_FRAC_BITS,
	localparam int NW = 2 * (CW + 1) + 1,
	localparam int MW = NW,
	localparam int SW = MW + WF + 1,
	localparam int RW = MW + 1,
	localparam int QB = tbc_pkg::QUOT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tbc_pkg::tag_t        tag_in,
	input  logic signed [NW-1:0] det,
	input  logic signed [NW-1:0] num [0:1],
	output tbc_pkg::tag_t        tag_out,
	output logic [QB-1:0]        quot [0:1],
	output logic                 neg [0:1],
	output logic                 ovf [0:1]
);

	tbc_pkg::tag_t tag_p1, tag_p2;
	tbc_pkg::tag_t tag_d [0:QB];
	logic [MW-1:0] md_p1, md_p2;
	logic [MW-1:0] md_d [0:QB];
	logic [SW-1:0] n_p1 [0:1];
	logic          neg_p1 [0:1];
	logic          neg_p2 [0:1];
	logic          ovf_p2 [0:1];
	logic [QB-1:0] low_p2 [0:1];
	logic [MW-1:0] r_p2 [0:1];
	logic [MW-1:0] r_d   [0:QB][0:1];
	logic [QB-1:0] q_d   [0:QB][0:1];
	logic [QB-1:0] low_d [0:QB][0:1];
	logic          neg_d [0:QB][0:1];
	logic          ovf_d [0:QB][0:1];

	logic [MW-1:0] md_c;
	assign md_c = det[NW-1] ? MW'(~det + 1'b1) : MW'(det);

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_p1 <= '0;
			tag_p2 <= '0;
		end else if (en) begin
			tag_p1 <= tag_in;
			tag_p2 <= tag_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_p1 <= md_c;
			md_p2 <= md_p1;
		end
	end

	assign tag_d[0] = tag_p2;
	assign md_d[0]  = md_p2;

	for (genvar k = 0; k < 2; k++) begin : g_lane
		logic [MW-1:0] mn_c;
		logic [SW-1:0] hi_c;

		assign mn_c = num[k][NW-1] ? MW'(~num[k] + 1'b1) : MW'(num[k]);
		assign hi_c = n_p1[k] >> QB;

		// Magnitudes, scale and add half the divisor for rounding
		always_ff @(posedge clk) begin
			if (en) begin
				n_p1[k]   <= (SW'(mn_c) << WF) + SW'(md_c >> 1);
				neg_p1[k] <= num[k][NW-1] ^ det[NW-1];
			end
		end

		// Overflow check and initial remainder
		always_ff @(posedge clk) begin
			if (en) begin
				ovf_p2[k] <= hi_c >= SW'(md_p1);
				r_p2[k]   <= MW'(hi_c);
				low_p2[k] <= n_p1[k][QB-1:0];
				neg_p2[k] <= neg_p1[k];
			end
		end

		assign r_d[0][k]   = r_p2[k];
		assign q_d[0][k]   = '0;
		assign low_d[0][k] = low_p2[k];
		assign neg_d[0][k] = neg_p2[k];
		assign ovf_d[0][k] = ovf_p2[k];

		assign quot[k] = q_d[QB][k];
		assign neg[k]  = neg_d[QB][k];
		assign ovf[k]  = ovf_d[QB][k];
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_d[j+1] <= '0;
			end else if (en) begin
				tag_d[j+1] <= tag_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				md_d[j+1] <= md_d[j];
			end
		end

		for (genvar k = 0; k < 2; k++) begin : g_lane_bit
			logic [RW-1:0] rs_c;
			logic          ge_c;

			assign rs_c = {r_d[j][k], low_d[j][k][QB-1]};
			assign ge_c = rs_c >= RW'(md_d[j]);

			// Shift in next dividend bit, subtract when it fits
			always_ff @(posedge clk) begin
				if (en) begin
					r_d[j+1][k]   <= ge_c ? MW'(rs_c - RW'(md_d[j])) : MW'(rs_c);
					q_d[j+1][k]   <= {q_d[j][k][QB-2:0], ge_c};
					low_d[j+1][k] <= low_d[j][k] << 1;
					neg_d[j+1][k] <= neg_d[j][k];
					ovf_d[j+1][k] <= ovf_d[j][k];
				end
			end
		end
	end

	assign tag_out = tag_d[QB];

endmodule

// ===== hw/rtl/triangle_barycentric_coordinates.sv =====
// Barycentric weights of a point in a 2D triangle, fully pipelined.
//
// Usage: present corners A, B, C and point P (signed fixed point, COORD_WIDTH
// bits each) on the query channel; each query transaction yields exactly one
// weights transaction with alpha, beta, gamma in signed Q.WEIGHT_FRAC_BITS,
// a degenerate flag (zero determinant, weights zero) and a saturated flag.
// Throughput: one transaction per cycle, sustained while the weights receiver keeps ready high.
// Pipeline: three stages for differences, products and determinant, two
// for divider setup, one per quotient bit (33) in the restoring divider,
// and the output register.
// Results leave in query order.
// Reset: arst_n clears all valid bits; the pipeline is empty afterwards and
// the query channel is ready at once.
// Stall: when the weights receiver holds ready low with a result waiting,
// the whole pipeline freezes and query ready drops; nothing is dropped or
// repeated, and the output register holds its transaction.
module triangle_barycentric_coordinates #(
	parameter int COORD_WIDTH      = tbc_pkg::COORD_WIDTH,
	parameter int WEIGHT_FRAC_BITS = tbc_pkg::WEIGHT_FRAC_BITS,
	localparam int NW = 2 * (COORD_WIDTH + 1) + 1,
	localparam int QB = tbc_pkg::QUOT_BITS,
	localparam int WW = tbc_pkg::WEIGHT_WIDTH,
	localparam int EW = WW + 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tbc_query_if.sink   query,
	tbc_weight_if.source weights
);

	logic en;
	logic front_v;
	logic signed [NW-1:0] det, num_a, num_b;
	logic signed [NW-1:0] num [0:1];
	tbc_pkg::tag_t tag_in, tag_out;
	logic [QB-1:0] quot [0:1];
	logic          neg [0:1];
	logic          ovf [0:1];

	logic signed [EW-1:0] w_c [0:1];
	logic                 sat_c [0:1];
	logic signed [EW-1:0] g_c;
	logic signed [WW-1:0] g_sat_c;
	logic                 g_ovf_c;

	logic                 valid_q;
	logic signed [WW-1:0] alpha_q, beta_q, gamma_q;
	logic                 degen_q, sat_q;

	// Global advance: move when the output register is free or being taken
	assign en          = !valid_q || weights.ready;
	assign query.ready = en;

	tbc_front #(
		.CW(COORD_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.valid (query.valid),
		.a_x   (query.a_x),
		.a_y   (query.a_y),
		.b_x   (query.b_x),
		.b_y   (query.b_y),
		.c_x   (query.c_x),
		.c_y   (query.c_y),
		.p_x   (query.p_x),
		.p_y   (query.p_y),
		.v_out (front_v),
		.det   (det),
		.num_a (num_a),
		.num_b (num_b)
	);

	assign num[0]       = num_a;
	assign num[1]       = num_b;
	assign tag_in.valid = front_v;
	assign tag_in.degen = det == '0;

	tbc_div #(
		.CW(COORD_WIDTH),
		.WF(WEIGHT_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (tag_in),
		.det    (det),
		.num    (num),
		.tag_out(tag_out),
		.quot   (quot),
		.neg    (neg),
		.ovf    (ovf)
	);

	// Sign and clamp each weight
	for (genvar k = 0; k < 2; k++) begin : g_weight
		logic [QB-1:0] lim_c;
		assign lim_c = neg[k] ? (QB'(1) << (WW - 1)) : ((QB'(1) << (WW - 1)) - QB'(1));
		assign sat_c[k] = ovf[k] || (quot[k] > lim_c);
		always_comb begin
			if (sat_c[k]) begin
				w_c[k] = neg[k] ? -(EW'(1) << (WW - 1)) : (EW'(1) << (WW - 1)) - EW'(1);
			end else begin
				w_c[k] = neg[k] ? -EW'(quot[k]) : EW'(quot[k]);
			end
		end
	end

	// Gamma from the clamped alpha and beta, then clamp
	assign g_c = (EW'(1) << WEIGHT_FRAC_BITS) - w_c[0] - w_c[1];
	always_comb begin
		g_ovf_c = 1'b1;
		if (g_c > (EW'(1) << (WW - 1)) - EW'(1)) begin
			g_sat_c = {1'b0, {(WW - 1){1'b1}}};
		end else if (g_c < -(EW'(1) << (WW - 1))) begin
			g_sat_c = {1'b1, {(WW - 1){1'b0}}};
		end else begin
			g_sat_c = WW'(g_c);
			g_ovf_c = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tag_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= tag_out.degen;
			if (tag_out.degen) begin
				alpha_q <= '0;
				beta_q  <= '0;
				gamma_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				alpha_q <= WW'(w_c[0]);
				beta_q  <= WW'(w_c[1]);
				gamma_q <= g_sat_c;
				sat_q   <= sat_c[0] || sat_c[1] || g_ovf_c;
			end
		end
	end

	assign weights.valid      = valid_q;
	assign weights.alpha      = alpha_q;
	assign weights.beta       = beta_q;
	assign weights.gamma      = gamma_q;
	assign weights.degenerate = degen_q;
	assign weights.saturated  = sat_q;

	// A degenerate triangle reports zero weights and no clamp
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid && weights.degenerate |->
		weights.alpha == '0 && weights.beta == '0 && weights.gamma == '0 &&
		!weights.saturated)
		else $error("degenerate result with nonzero weights");

	// Unclamped weights sum to one
	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid && !weights.degenerate && !weights.saturated |->
		EW'(weights.alpha) + EW'(weights.beta) + EW'(weights.gamma) ==
		(EW'(1) << WEIGHT_FRAC_BITS))
		else $error("weights do not sum to one");

	// A result taken with no new one behind it empties the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid && weights.ready && !tag_out.valid |=> !weights.valid)
		else $error("output register did not drain");

endmodule

// ===== verif/triangle_barycentric_coordinates_test.sv =====
// Self-checking testbench for the triangle barycentric coordinates block.
module triangle_barycentric_coordinates_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LATENCY      = 39;
	localparam int  CYCLE_LIMIT  = 2000000;
	localparam int  ITEMS_PER_PH = 630;
	localparam int  HOLD_CYCLES  = 400;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
	localparam logic signed [31:0] CMAX    = 32'sh7fff_ffff;
	localparam logic signed [31:0] CMIN    = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by, cx, cy, px, py;
	} query_t;

	typedef struct {
		logic signed [31:0] alpha, beta, gamma;
		logic               degen, sat;
	} weights_t;

	typedef struct {
		query_t   q;
		logic     known;
		weights_t w;
	} vector_t;

	logic clk;
	logic arst_n;

	tbc_query_if  q_if ();
	tbc_weight_if w_if ();

	triangle_barycentric_coordinates u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (q_if.sink),
		.weights(w_if.source)
	);

	weights_t pending_weights[$];
	int       mismatches = 0;
	int       cycles     = 0;
	int       tx_idle    = 0;
	int       rx_idle    = 0;
	int       hold_left  = 0;
	logic     hold_req   = 1'b0;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Guard the run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Round and saturate num/det to a Q8.24 weight
	function automatic logic signed [31:0] quotient_q24(logic signed [127:0] num,
			logic signed [127:0] den, ref logic sat);
		logic         neg;
		logic [127:0] mn, md, qv, lim;
		neg = num[127] ^ den[127];
		mn  = num[127] ? -num : num;
		md  = den[127] ? -den : den;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		mn  = mn << 24;
		qv  = (mn + (md >> 1)) / md;
		if (qv > lim) begin
			sat = 1'b1;
			return neg ? CMIN : CMAX;
		end
		return neg ? -qv[31:0] : qv[31:0];
	endfunction

	// Barycentric weights of P in triangle A, B, C
	function automatic weights_t solve_weights(query_t q);
		logic signed [127:0] t00, t01, t10, t11, vx, vy, det, na, nb;
		longint              g;
		weights_t            w;
		t00 = 128'(q.ax) - 128'(q.cx);
		t01 = 128'(q.bx) - 128'(q.cx);
		t10 = 128'(q.ay) - 128'(q.cy);
		t11 = 128'(q.by) - 128'(q.cy);
		vx  = 128'(q.px) - 128'(q.cx);
		vy  = 128'(q.py) - 128'(q.cy);
		det = t00 * t11 - t01 * t10;
		w   = '{alpha: 0, beta: 0, gamma: 0, degen: 1'b0, sat: 1'b0};
		if (det == 0) begin
			w.degen = 1'b1;
			return w;
		end
		na      = t11 * vx - t01 * vy;
		nb      = t00 * vy - t10 * vx;
		w.alpha = quotient_q24(na, det, w.sat);
		w.beta  = quotient_q24(nb, det, w.sat);
		g = longint'(ONE_Q24) - longint'(w.alpha) - longint'(w.beta);
		if (g > longint'(CMAX)) begin
			g     = CMAX;
			w.sat = 1'b1;
		end
		if (g < longint'(CMIN)) begin
			g     = CMIN;
			w.sat = 1'b1;
		end
		w.gamma = g[31:0];
		return w;
	endfunction

	// Random coordinate within +-span around a base
	function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
		return base + $signed($urandom_range(2 * span)) - span;
	endfunction

	// Mostly well-formed triangles, with collinear, tiny and raw noise mixed in
	function automatic query_t random_query();
		query_t q;
		int     mode, span, k;
		logic signed [31:0] dx, dy;
		mode = $urandom_range(9);
		span = 1 << $urandom_range(24, 4);
		q.cx = near(0, 1 << 28);
		q.cy = near(0, 1 << 28);
		q.ax = near(q.cx, span);
		q.ay = near(q.cy, span);
		q.bx = near(q.cx, span);
		q.by = near(q.cy, span);
		q.px = near(q.cx, span);
		q.py = near(q.cy, span);
		case (mode)
			6, 7: begin
				q.ax = $urandom(); q.ay = $urandom(); q.bx = $urandom();
				q.by = $urandom(); q.cx = $urandom(); q.cy = $urandom();
				q.px = $urandom(); q.py = $urandom();
			end
			8: begin
				dx   = near(0, span);
				dy   = near(0, span);
				k    = $urandom_range(4);
				q.ax = q.cx + dx;
				q.ay = q.cy + dy;
				q.bx = q.cx - k * dx;
				q.by = q.cy - k * dy;
			end
			9: begin
				q.ax = near(q.cx, 3);
				q.ay = near(q.cy, 3);
				q.bx = near(q.cx, 3);
				q.by = near(q.cy, 3);
				q.px = $urandom();
				q.py = $urandom();
			end
			default: ;
		endcase
		return q;
	endfunction

	// Offer one transaction and record its expected weights on acceptance
	task automatic send_query(query_t q, logic known, weights_t w);
		weights_t pred;
		q_if.valid <= 1'b1;
		q_if.a_x <= q.ax; q_if.a_y <= q.ay;
		q_if.b_x <= q.bx; q_if.b_y <= q.by;
		q_if.c_x <= q.cx; q_if.c_y <= q.cy;
		q_if.p_x <= q.px; q_if.p_y <= q.py;
		do @(posedge clk); while (!q_if.ready);
		pred = known ? w : solve_weights(q);
		pending_weights.push_back(pred);
		if ($urandom_range(99) < tx_idle) begin
			q_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		q_if.valid <= 1'b0;
		while (pending_weights.size() != 0)
			@(posedge clk);
	endtask

	// Drive the receiver ready, with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_if.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req   = 1'b0;
			hold_left  = HOLD_CYCLES;
			w_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left  = hold_left - 1;
			w_if.ready <= 1'b0;
		end else begin
			w_if.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Compare each weights transaction with the oldest expectation
	always @(posedge clk) begin
		weights_t e;
		if (arst_n && w_if.valid && w_if.ready) begin
			if (pending_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected weights: alpha=%0d beta=%0d gamma=%0d",
						w_if.alpha, w_if.beta, w_if.gamma);
			end else begin
				e = pending_weights.pop_front();
				if (w_if.alpha !== e.alpha || w_if.beta !== e.beta
						|| w_if.gamma !== e.gamma || w_if.degenerate !== e.degen
						|| w_if.saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"weights mismatch: exp a=%0d b=%0d g=%0d dg=%b st=%b",
							" got a=%0d b=%0d g=%0d dg=%b st=%b"},
							e.alpha, e.beta, e.gamma, e.degen, e.sat,
							w_if.alpha, w_if.beta, w_if.gamma,
							w_if.degenerate, w_if.saturated);
				end
			end
		end
	end

	// Stimulus
	initial begin
		vector_t  dir[$];
		weights_t zero_w;
		weights_t q24;
		vector_t  v;
		int       ph;
		zero_w = '{alpha: 0, beta: 0, gamma: 0, degen: 1'b1, sat: 1'b0};

		q_if.valid = 1'b0;
		q_if.a_x = 0; q_if.a_y = 0; q_if.b_x = 0; q_if.b_y = 0;
		q_if.c_x = 0; q_if.c_y = 0; q_if.p_x = 0; q_if.p_y = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: unit triangle corners, degenerate cases, extremes
		q24 = '{alpha: 0, beta: 0, gamma: ONE_Q24, degen: 1'b0, sat: 1'b0};
		dir.push_back('{'{ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, 0}, 1'b1, q24});
		q24 = '{alpha: ONE_Q24, beta: 0, gamma: 0, degen: 1'b0, sat: 1'b0};
		dir.push_back('{'{ONE_Q16, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 0}, 1'b1, q24});
		q24 = '{alpha: 0, beta: ONE_Q24, gamma: 0, degen: 1'b0, sat: 1'b0};
		dir.push_back('{'{ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16}, 1'b1, q24});
		dir.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, zero_w});
		dir.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b1, zero_w});
		dir.push_back('{'{CMIN, CMIN, CMAX, CMAX, 0, 0, CMAX, CMIN}, 1'b1, zero_w});
		dir.push_back('{'{ONE_Q16, 0, 2 * ONE_Q16, 0, 0, 0, 5, 7}, 1'b1, zero_w});
		dir.push_back('{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0, zero_w});
		dir.push_back('{'{CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b0, zero_w});
		dir.push_back('{'{CMAX, 0, 0, CMAX, CMIN, CMIN, 0, 0}, 1'b0, zero_w});
		dir.push_back('{'{1, 0, 0, 1, 0, 0, CMAX, CMAX}, 1'b0, zero_w});
		dir.push_back('{'{1, 0, 0, 1, 0, 0, CMIN, CMAX}, 1'b0, zero_w});
		dir.push_back('{'{1, 0, 0, 1, 0, 0, CMIN, CMIN}, 1'b0, zero_w});
		dir.push_back('{'{3, 0, 0, 3, 0, 0, 1, 1}, 1'b0, zero_w});
		dir.push_back('{'{3, 0, 0, 3, 0, 0, 2, 2}, 1'b0, zero_w});
		dir.push_back('{'{-32'sd1, -32'sd1, 32'sd1, -32'sd1, 0, 32'sd1, 0, 0},
			1'b0, zero_w});
		dir.push_back('{'{ONE_Q16, ONE_Q16, -ONE_Q16, ONE_Q16, 0, -ONE_Q16, 17, -9},
			1'b0, zero_w});

		for (ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 24 : (ph == 1) ? 64 : 0;
			rx_idle = (ph == 0) ? 64 : (ph == 1) ? 24 : 0;
			if (ph == 0)
				foreach (dir[i])
					send_query(dir[i].q, dir[i].known, dir[i].w);
			// Stall the receiver long enough for the pipeline to back up
			if (ph == 1)
				hold_req = 1'b1;
			repeat (ITEMS_PER_PH) begin
				v.q = random_query();
				send_query(v.q, 1'b0, zero_w);
			end
			drain();
		end

		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && pending_weights.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
